// ===== rtl/core/scm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the serial cartridge memory slave core.
// ----------------------------------------------------------------------------
package scm_pkg;

   localparam int unsigned STORE_BYTES_DEFAULT = 65536;

   localparam int unsigned LEN_W  = 17;
   localparam int unsigned PTR_W  = 24;
   localparam int unsigned CNT_W  = 5;
   localparam int unsigned LADR_W = 16;

   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 8;

   localparam logic [7:0] CMD_STATUS   = 8'h00;
   localparam logic [7:0] CMD_ADDR24   = 8'hA8;
   localparam logic [7:0] CMD_ADDR16   = 8'hA0;
   localparam logic [7:0] CMD_READ     = 8'hD0;
   localparam logic [7:0] CMD_READ_ALT = 8'hD8;

   typedef enum logic [1:0] {
      ACT_PULSE   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_LOAD    = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      PH_COMMAND = 3'd0,
      PH_ADDR24  = 3'd1,
      PH_ADDR16  = 3'd2,
      PH_STATUS  = 3'd3,
      PH_STREAM  = 3'd4,
      PH_WAIT    = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   typedef struct packed {
      logic       drive;
      logic       reading;
      logic       from_store;
      logic [2:0] bit_sel;
   } pulse_out_type;

endpackage

// ===== rtl/core/serial_cartridge_memory_slave_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_cartridge_memory_slave_core
// Slave side of a clocked serial cartridge link, one serial clock pulse per
// word, with a loadable byte store and a post-increment read stream.
// ----------------------------------------------------------------------------
// The core takes one word in every clock cycle unless the result stream
// stalls, and presents one result word for every clock pulse word: the word
// passes an input register, the command and address logic with the store's
// registered read port, and the result register. Load, release and idle
// words give no result. The store is not cleared after reset, so it must be
// loaded before it is read; the user must see that the image length register
// is written only while no word is in flight, as the core does not enforce it.
module serial_cartridge_memory_slave_core
   import scm_pkg::*;
#(
   parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_in[0], load_address[16:1], load_byte[24:17]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // data_out[0], drive_enable[1], reading[2], error[3]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [LEN_W-1:0]       csr_wr_data
);

   localparam int unsigned AW = $clog2(STORE_BYTES);

   logic [LEN_W-1:0]  image_length_ff;

   logic              s1_valid_ff;
   action_type        s1_action_ff;
   logic              s1_bit_ff;
   logic [LADR_W-1:0] s1_load_addr_ff;
   logic [7:0]        s1_load_byte_ff;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [PTR_W-1:0]  in_shift_ff, in_shift_in;
   logic [PTR_W-1:0]  read_pointer_ff, read_pointer_in;
   logic              error_ff, error_in;
   logic              fetch;

   pulse_out_type     pulse_out;

   logic              s2_valid_ff;
   pulse_out_type     s2_out_ff;
   logic              s2_error_ff;
   logic              byte_ok_ff;

   logic              rsp_valid_ff;
   logic [3:0]        rsp_fields_ff;

   logic              en1, en2, en3, process;
   logic [PTR_W-1:0]  shifted;
   logic [CNT_W-1:0]  count_inc;
   logic [PTR_W-1:0]  load_addr_ext;
   logic              load_ok;
   logic              fetch_ok;
   logic [7:0]        store_q;
   logic              store_bit;

   assign en3        = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign process    = s1_valid_ff && en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_length_ff <= '0;
      end else if (csr_wr_en) begin
         image_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         s1_action_ff    <= action_type'(req_tuser);
         s1_bit_ff       <= req_tdata[0];
         s1_load_addr_ff <= req_tdata[16:1];
         s1_load_byte_ff <= req_tdata[24:17];
      end
   end

   assign shifted   = {in_shift_ff[PTR_W-2:0], s1_bit_ff};
   assign count_inc = bit_count_ff + CNT_W'(1);

   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      in_shift_in     = in_shift_ff;
      read_pointer_in = read_pointer_ff;
      error_in        = error_ff;
      fetch           = 1'b0;
      unique case (s1_action_ff)
         ACT_RELEASE: begin
            if (phase_ff != PH_ERROR) begin
               phase_in     = PH_COMMAND;
               bit_count_in = '0;
               in_shift_in  = '0;
            end
         end
         ACT_PULSE: begin
            unique case (phase_ff)
               PH_COMMAND: begin
                  in_shift_in  = shifted;
                  bit_count_in = count_inc;
                  if (count_inc >= CNT_W'(8)) begin
                     bit_count_in = '0;
                     in_shift_in  = '0;
                     unique case (shifted[7:0])
                        CMD_STATUS:             phase_in = PH_STATUS;
                        CMD_ADDR24:             phase_in = PH_ADDR24;
                        CMD_ADDR16:             phase_in = PH_ADDR16;
                        CMD_READ, CMD_READ_ALT: phase_in = PH_STREAM;
                        default: begin
                           phase_in = PH_ERROR;
                           error_in = 1'b1;
                        end
                     endcase
                  end
               end
               PH_ADDR24, PH_ADDR16: begin
                  in_shift_in  = shifted;
                  bit_count_in = count_inc;
                  if (count_inc >= ((phase_ff == PH_ADDR24) ? CNT_W'(24) : CNT_W'(16))) begin
                     read_pointer_in = shifted;
                     bit_count_in    = '0;
                     in_shift_in     = '0;
                     phase_in        = PH_WAIT;
                  end
               end
               PH_STATUS: begin
                  bit_count_in = count_inc;
                  if (count_inc >= CNT_W'(8)) begin
                     bit_count_in = '0;
                     phase_in     = PH_WAIT;
                  end
               end
               PH_STREAM: begin
                  if (bit_count_ff == '0) begin
                     fetch           = 1'b1;
                     read_pointer_in = read_pointer_ff + PTR_W'(1);
                  end
                  bit_count_in = {{(CNT_W-3){1'b0}}, count_inc[2:0]};
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pulse_out.drive      = (phase_ff == PH_STATUS) || (phase_ff == PH_STREAM);
      pulse_out.reading    = (phase_ff == PH_STREAM);
      pulse_out.from_store = (phase_ff == PH_STREAM);
      pulse_out.bit_sel    = bit_count_ff[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_COMMAND;
         bit_count_ff    <= '0;
         in_shift_ff     <= '0;
         read_pointer_ff <= '0;
         error_ff        <= 1'b0;
      end else if (process) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         in_shift_ff     <= in_shift_in;
         read_pointer_ff <= read_pointer_in;
         error_ff        <= error_in;
      end
   end

   assign load_addr_ext = {{(PTR_W-LADR_W){1'b0}}, s1_load_addr_ff};
   assign load_ok       = {1'b0, load_addr_ext} < (PTR_W+1)'(STORE_BYTES);
   assign fetch_ok      = ({1'b0, read_pointer_ff} < (PTR_W+1)'(STORE_BYTES))
                       && (read_pointer_ff < {{(PTR_W-LEN_W){1'b0}}, image_length_ff});

   scm_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (process && (s1_action_ff == ACT_LOAD) && load_ok),
      .wr_addr (load_addr_ext[AW-1:0]),
      .wr_data (s1_load_byte_ff),
      .rd_en   (process && fetch),
      .rd_addr (read_pointer_ff[AW-1:0]),
      .rd_data (store_q)
   );

   always_ff @(posedge clock) begin
      if (process && fetch) begin
         byte_ok_ff <= fetch_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff && (s1_action_ff == ACT_PULSE);
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         s2_out_ff   <= pulse_out;
         s2_error_ff <= error_in;
      end
   end

   assign store_bit = s2_out_ff.from_store && byte_ok_ff && store_q[~s2_out_ff.bit_sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         rsp_fields_ff <= {s2_error_ff, s2_out_ff.reading, s2_out_ff.drive, store_bit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-4){1'b0}}, rsp_fields_ff};

   a_error_sticky : assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag cleared without reset");

   a_error_phase : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> error_ff)
      else $error("error phase without error flag");

   a_data_driven : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fields_ff[0] && !rsp_fields_ff[1]))
      else $error("data bit set while the line is not driven");

   a_reading_drives : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fields_ff[2]) |-> (rsp_fields_ff[1] && !rsp_fields_ff[3]))
      else $error("read stream word without drive or with error");

endmodule

// ===== rtl/core/scm_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_store
// Byte store of the cartridge image: one write port and one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module scm_store
   import scm_pkg::*;
#(
   parameter int unsigned DEPTH = STORE_BYTES_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
